@@ src/detection_result_frame_parser_macros.svh @@
// Assertion macros for the checker file of the frame parser.
`ifndef DETECTION_RESULT_FRAME_PARSER_MACROS_SVH
`define DETECTION_RESULT_FRAME_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRFP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DRFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/drfp_pkg.sv @@
// Package with the frame layout constants and status codes of the frame parser.
package drfp_pkg;

   localparam int unsigned POS_W = 17;
   localparam int unsigned LEN_W = POS_W + 1;

   localparam logic [POS_W-1:0] POS_MAX     = '1;
   localparam logic [POS_W-1:0] MAGIC_BYTES = 17'd4;
   localparam logic [POS_W-1:0] LEN_LO_POS  = 17'd4;
   localparam logic [POS_W-1:0] LEN_HI_POS  = 17'd5;
   localparam logic [POS_W-1:0] CSUM_POS    = 17'd6;
   localparam logic [POS_W-1:0] HDR_LEN     = 17'd7;
   localparam logic [POS_W-1:0] PKG_ID_POS  = 17'd7;
   localparam logic [POS_W-1:0] STATE_POS   = 17'd10;
   localparam logic [POS_W-1:0] ERROR_POS   = 17'd11;
   localparam logic [POS_W-1:0] COUNT_POS   = 17'd12;
   localparam logic [POS_W-1:0] AREA_START  = 17'd13;

   // Frame lengths below which a field is missing.
   localparam logic [LEN_W-1:0] LEN_NEED_PKG   = 18'd8;
   localparam logic [LEN_W-1:0] LEN_NEED_STATE = 18'd12;
   localparam logic [LEN_W-1:0] LEN_NEED_COUNT = 18'd13;

   localparam logic [31:0] FRAME_MAGIC = 32'h474C_4102;
   localparam logic [7:0]  ZERO_BYTE   = 8'h00;

   typedef enum logic [1:0] {
      PHASE_INDEX,
      PHASE_LEVEL,
      PHASE_WARN
   } record_phase_type;

   typedef enum logic [2:0] {
      STATUS_OK,
      STATUS_SHORT_HEADER,
      STATUS_BAD_MAGIC,
      STATUS_SHORT_DATA,
      STATUS_CHECKSUM,
      STATUS_PACKAGE_ID,
      STATUS_STATE_ERROR,
      STATUS_TRUNCATED
   } frame_status_type;

endpackage

@@ src/detection_result_frame_parser.sv @@
// Detection result frame parser: byte stream in, area records and frame status out.
//
// Usage: frame bytes enter on the req_ channel, one word per byte, with
// req_last_byte high on the final byte of a frame. The block checks the
// header magic, the valid length, the additive checksum, the package id and
// the state and error bytes, and emits one rsp_ word for every byte that
// completes a 3-byte area record or ends the frame. The final byte's word
// carries rsp_frame_done and rsp_frame_status; records of a frame whose
// status is not zero are to be discarded by the receiver.
// A result word is registered and appears in the cycle after the byte that causes it.
// Throughput: one byte per cycle unless stalled; the per-byte work is a position counter
// step, one 8-bit add and a few 18-bit length compares ahead of the result
// register.
// Bytes that cause no result pass through without using the output register.
// Stall: while a result word waits in the output register with rsp_ready
// low, req_ready is low; once the word is taken, bytes flow again in the
// same cycle.
// Reset clears all frame state and the output valid flag; the next byte is
// taken as the first byte of a frame.
module detection_result_frame_parser
   import drfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_record_valid,
   output logic [7:0] rsp_area_index,
   output logic [7:0] rsp_safety_level,
   output logic [7:0] rsp_warning_flag,
   output logic       rsp_frame_done,
   output logic [2:0] rsp_frame_status,
   output logic [7:0] rsp_area_count
);

   // Frame state.
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [31:0]       magic_ff, magic_in;
   logic [15:0]       vlen_ff, vlen_in;
   logic [7:0]        hdr_csum_ff, hdr_csum_in;
   logic [7:0]        sum_ff, sum_in;
   logic              pkg_bad_ff, pkg_bad_in;
   logic              se_bad_ff, se_bad_in;
   logic [7:0]        areas_ff, areas_in;
   logic [7:0]        done_ff, done_in;
   logic [15:0]       rec_bytes_ff, rec_bytes_in;
   record_phase_type  phase_ff, phase_in;

   // Output register.
   logic              rsp_valid_ff;
   logic              rec_valid_ff, rec_valid_in;
   logic [7:0]        idx_ff, idx_in;
   logic [7:0]        lvl_ff, lvl_in;
   logic [7:0]        warn_ff, warn_in;
   logic              done_flag_ff;
   frame_status_type  status_ff, status_in;
   logic [7:0]        count_ff;

   logic              accept;
   logic              emit;
   logic [LEN_W-1:0]  frame_len;
   logic [LEN_W-1:0]  data_end;
   logic              in_data;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign data_end  = LEN_W'(HDR_LEN) + LEN_W'(vlen_ff);
   assign in_data   = (pos_ff >= HDR_LEN) && (LEN_W'(pos_ff) < data_end);
   assign frame_len = LEN_W'(pos_ff) + LEN_W'(1);

   always_comb begin
      magic_in     = magic_ff;
      vlen_in      = vlen_ff;
      hdr_csum_in  = hdr_csum_ff;
      sum_in       = sum_ff;
      pkg_bad_in   = pkg_bad_ff;
      se_bad_in    = se_bad_ff;
      areas_in     = areas_ff;
      done_in      = done_ff;
      rec_bytes_in = rec_bytes_ff;
      phase_in     = phase_ff;
      rec_valid_in = 1'b0;
      idx_in       = ZERO_BYTE;
      lvl_in       = ZERO_BYTE;
      warn_in      = ZERO_BYTE;
      status_in    = STATUS_OK;

      if (pos_ff < MAGIC_BYTES) begin
         magic_in = {req_data_byte, magic_ff[31:8]};
      end else if (pos_ff == LEN_LO_POS) begin
         vlen_in = {vlen_ff[15:8], req_data_byte};
      end else if (pos_ff == LEN_HI_POS) begin
         vlen_in = {req_data_byte, vlen_ff[7:0]};
      end else if (pos_ff == CSUM_POS) begin
         hdr_csum_in = req_data_byte;
      end

      if (in_data) begin
         sum_in = sum_ff + req_data_byte;
      end
      if (pos_ff == PKG_ID_POS) begin
         pkg_bad_in = (req_data_byte != ZERO_BYTE);
      end
      if ((pos_ff == STATE_POS || pos_ff == ERROR_POS) && req_data_byte != ZERO_BYTE) begin
         se_bad_in = 1'b1;
      end
      if (pos_ff == COUNT_POS) begin
         areas_in = req_data_byte;
      end

      if (pos_ff >= AREA_START && done_ff < areas_ff) begin
         case (phase_ff)
            PHASE_INDEX: begin
               rec_bytes_in = {ZERO_BYTE, req_data_byte};
               phase_in     = PHASE_LEVEL;
            end
            PHASE_LEVEL: begin
               rec_bytes_in = {req_data_byte, rec_bytes_ff[7:0]};
               phase_in     = PHASE_WARN;
            end
            default: begin
               rec_valid_in = 1'b1;
               idx_in       = rec_bytes_ff[7:0];
               lvl_in       = rec_bytes_ff[15:8];
               warn_in      = req_data_byte;
               done_in      = done_ff + 8'd1;
               phase_in     = PHASE_INDEX;
               rec_bytes_in = '0;
            end
         endcase
      end

      // The checks run on the state as updated by the final byte itself.
      if (req_last_byte) begin
         if (frame_len < LEN_W'(HDR_LEN)) begin
            status_in = STATUS_SHORT_HEADER;
         end else if (magic_in != FRAME_MAGIC) begin
            status_in = STATUS_BAD_MAGIC;
         end else if (frame_len < LEN_W'(HDR_LEN) + LEN_W'(vlen_in)) begin
            status_in = STATUS_SHORT_DATA;
         end else if (sum_in != hdr_csum_in) begin
            status_in = STATUS_CHECKSUM;
         end else if (frame_len < LEN_NEED_PKG) begin
            status_in = STATUS_TRUNCATED;
         end else if (pkg_bad_in) begin
            status_in = STATUS_PACKAGE_ID;
         end else if (frame_len < LEN_NEED_STATE) begin
            status_in = STATUS_TRUNCATED;
         end else if (se_bad_in) begin
            status_in = STATUS_STATE_ERROR;
         end else if (frame_len < LEN_NEED_COUNT || done_in < areas_in) begin
            status_in = STATUS_TRUNCATED;
         end
      end

      pos_in = (pos_ff != POS_MAX) ? pos_ff + POS_W'(1) : pos_ff;
      emit   = rec_valid_in || req_last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_last_byte)) begin
         pos_ff       <= '0;
         magic_ff     <= '0;
         vlen_ff      <= '0;
         hdr_csum_ff  <= '0;
         sum_ff       <= '0;
         pkg_bad_ff   <= 1'b0;
         se_bad_ff    <= 1'b0;
         areas_ff     <= '0;
         done_ff      <= '0;
         rec_bytes_ff <= '0;
         phase_ff     <= PHASE_INDEX;
      end else if (accept) begin
         pos_ff       <= pos_in;
         magic_ff     <= magic_in;
         vlen_ff      <= vlen_in;
         hdr_csum_ff  <= hdr_csum_in;
         sum_ff       <= sum_in;
         pkg_bad_ff   <= pkg_bad_in;
         se_bad_ff    <= se_bad_in;
         areas_ff     <= areas_in;
         done_ff      <= done_in;
         rec_bytes_ff <= rec_bytes_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rec_valid_ff <= rec_valid_in;
         idx_ff       <= idx_in;
         lvl_ff       <= lvl_in;
         warn_ff      <= warn_in;
         done_flag_ff <= req_last_byte;
         status_ff    <= status_in;
         count_ff     <= areas_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_record_valid = rec_valid_ff;
   assign rsp_area_index   = idx_ff;
   assign rsp_safety_level = lvl_ff;
   assign rsp_warning_flag = warn_ff;
   assign rsp_frame_done   = done_flag_ff;
   assign rsp_frame_status = status_ff;
   assign rsp_area_count   = count_ff;

endmodule

@@ src/drfp_checker.sv @@
// Port-level assertions for the frame parser and their bind to the top level.
`include "detection_result_frame_parser_macros.svh"

module drfp_checker
   import drfp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_record_valid,
   input logic [7:0] rsp_area_index,
   input logic [7:0] rsp_safety_level,
   input logic [7:0] rsp_warning_flag,
   input logic       rsp_frame_done,
   input logic [2:0] rsp_frame_status
);

   // Every result word is either a completed record or the end of a frame.
   `DRFP_ASSERT_SAME(a_word_has_cause, clock, reset, rsp_valid, rsp_record_valid || rsp_frame_done, "result word without record or frame end")

   // Status is only reported with the end of a frame.
   `DRFP_ASSERT_SAME(a_status_only_at_end, clock, reset, rsp_valid && !rsp_frame_done, rsp_frame_status == STATUS_OK, "status set on a word that does not end a frame")

   // Record fields are zero on a word that carries no record.
   `DRFP_ASSERT_SAME(a_empty_record_zero, clock, reset, rsp_valid && !rsp_record_valid, rsp_area_index == ZERO_BYTE && rsp_safety_level == ZERO_BYTE && rsp_warning_flag == ZERO_BYTE, "record fields set without a record")

   // With the output register empty, the block must take bytes.
   `DRFP_ASSERT_SAME(a_ready_when_empty, clock, reset, !rsp_valid, req_ready, "input stalled while no result is waiting")

   // A stalled result word stays on the port.
   `DRFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_frame_status) && $stable(rsp_area_index), "result word dropped or changed under stall")

endmodule

bind detection_result_frame_parser drfp_checker u_drfp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_record_valid (rsp_record_valid),
   .rsp_area_index   (rsp_area_index),
   .rsp_safety_level (rsp_safety_level),
   .rsp_warning_flag (rsp_warning_flag),
   .rsp_frame_done   (rsp_frame_done),
   .rsp_frame_status (rsp_frame_status)
);
